// File: sv/block_inode_bitmap_allocator_core_defines.svh
// Assertion macros for the block/inode bitmap allocator.
// Included by the modules that carry assertions; no other dependencies.
`ifndef BLOCK_INODE_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_INODE_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked at every clock edge out of reset
`define BIBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
// next-cycle implication
`define BIBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define BIBA_ASSERT_NOW(label, ante, cons)
`define BIBA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/biba_pkg.sv
// Shared constants, types and opcodes of the block/inode bitmap allocator.
// No dependencies; imported by every module of the block.
package biba_pkg;

  // map geometry
  localparam int BLOCK_COUNT      = 128;
  localparam int INODE_COUNT      = 32;
  localparam int FIRST_USER_INODE = 11;

  // the bitmaps are scanned one 16-bit word per step
  localparam int WORD_W    = 16;
  localparam int POS_W     = $clog2(WORD_W);
  localparam int ZCNT_W    = $clog2(WORD_W + 1);
  localparam int BLK_ROWS  = BLOCK_COUNT / WORD_W;
  localparam int INO_ROWS  = INODE_COUNT / WORD_W;
  localparam int ROW_W     = $clog2(BLK_ROWS);
  localparam int INO_ROW_W = (INO_ROWS > 1) ? $clog2(INO_ROWS) : 1;

  localparam int INO_FIRST_ROW = FIRST_USER_INODE / WORD_W;
  localparam int INO_FIRST_BIT = FIRST_USER_INODE % WORD_W;

  // field widths
  localparam int OP_W      = 3;
  localparam int BLK_IDX_W = 7;
  localparam int INO_IDX_W = 5;
  localparam int BLK_CNT_W = 8;
  localparam int INO_CNT_W = 6;

  // opcodes
  localparam logic [OP_W-1:0] OP_FIND_BLOCK = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND_INODE = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_USED  = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_FREE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK      = 3'd4;

  // block map write port
  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } map_wr_t;

endpackage

// File: sv/biba_word_scan.sv
// Shared word unit: first zero bit at or above a start position, and zero count.
// Depends on biba_pkg.
module biba_word_scan
  import biba_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [POS_W-1:0]  start_bit,
  output logic              found,
  output logic [POS_W-1:0]  pos,
  output logic [ZCNT_W-1:0] zeros
);

  logic [WORD_W-1:0] masked;

  // bits below the start position count as used
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      masked[i] = word[i] | (POS_W'(i) < start_bit);
    end
  end

  // priority search from the low end
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        found = 1'b1;
        pos   = POS_W'(i);
      end
    end
  end

  // free bits in the whole word
  always_comb begin
    zeros = '0;
    for (int i = 0; i < WORD_W; i++) begin
      zeros = zeros + ZCNT_W'(!word[i]);
    end
  end

endmodule

// File: sv/biba_block_map.sv
// Block-use bitmap: BLK_ROWS words of WORD_W bits, one write and one registered read.
// Row valid bits make an unwritten row read as all free after reset. Depends on biba_pkg.
module biba_block_map
  import biba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ROW_W-1:0]  rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  map_wr_t           wr
);

  logic [WORD_W-1:0]   mem [BLK_ROWS];
  logic [BLK_ROWS-1:0] row_vld;
  logic [WORD_W-1:0]   rdata_q;
  logic                rvld_q;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_q <= mem[rd_addr];
  end

  // row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld[wr.addr] <= 1'b1;
      end
      rvld_q <= row_vld[rd_addr];
    end
  end

  assign rd_data = rvld_q ? rdata_q : '0;

endmodule

// File: sv/block_inode_bitmap_allocator_core.sv
// Block/inode bitmap allocator: find-first-free, mark, and free-space check.
// One item at a time; a shared 16-bit word unit scans one map word per cycle.
// Steps: IDLE accepts, FETCH reads a map row, SCAN walks the rows or MARK writes
// one bit, DONE loads the result; a mark with no block and other opcodes go
// from IDLE straight to DONE. A new item is taken only back in IDLE.
// rst (sync, high): maps all free, counters full, no result pending.
`include "block_inode_bitmap_allocator_core_defines.svh"
module block_inode_bitmap_allocator_core
  import biba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [6:0] block_index, [7] block_valid, [12:8] inode_index, [13] inode_valid,
  // [21:14] blocks_needed, [23:22] zero
  input  logic [23:0] s_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] status, [8:1] block_number, [13:9] free_inode_index, [21:14] blocks_free,
  // [27:22] inodes_free, [31:28] zero
  output logic [31:0] m_tdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t               state;
  logic [OP_W-1:0]      op;
  logic [BLK_IDX_W-1:0] blk_idx;
  logic [7:0]           needed;
  logic [ROW_W-1:0]     scan_row;
  logic [BLK_CNT_W-1:0] acc;
  logic [INODE_COUNT-1:0] inode_map;
  logic [BLK_CNT_W-1:0] free_blk;
  logic [INO_CNT_W-1:0] free_ino;
  logic                 res_status;
  logic [BLK_CNT_W-1:0] res_blk_num;
  logic [INO_IDX_W-1:0] res_ino;

  // input fields
  logic [OP_W-1:0]      in_op;
  logic [BLK_IDX_W-1:0] in_blk_idx;
  logic                 in_blk_vld;
  logic [INO_IDX_W-1:0] in_ino_idx;
  logic                 in_ino_vld;
  logic [7:0]           in_needed;
  logic                 accept;

  assign in_op      = s_tuser;
  assign in_blk_idx = s_tdata[6:0];
  assign in_blk_vld = s_tdata[7];
  assign in_ino_idx = s_tdata[12:8];
  assign in_ino_vld = s_tdata[13];
  assign in_needed  = s_tdata[21:14];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;

  // block map and its read address: next row is fetched while scanning this one
  logic [ROW_W-1:0]  rd_addr;
  logic [WORD_W-1:0] blk_rdata;
  map_wr_t           map_wr;

  assign rd_addr = (state == S_SCAN) ? scan_row + ROW_W'(1) : scan_row;

  biba_block_map u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (blk_rdata),
    .wr      (map_wr)
  );

  // shared word unit
  logic [INO_ROW_W-1:0] ino_row;
  logic [WORD_W-1:0]    scan_word;
  logic [POS_W-1:0]     start_bit;
  logic                 w_found;
  logic [POS_W-1:0]     w_pos;
  logic [ZCNT_W-1:0]    w_zeros;
  logic                 find_ino;

  assign find_ino  = (op == OP_FIND_INODE);
  assign ino_row   = scan_row[INO_ROW_W-1:0];
  assign scan_word = find_ino ? inode_map[ino_row*WORD_W +: WORD_W] : blk_rdata;
  assign start_bit = (find_ino && scan_row == ROW_W'(INO_FIRST_ROW)) ?
                     POS_W'(INO_FIRST_BIT) : '0;

  biba_word_scan u_scan (
    .word      (scan_word),
    .start_bit (start_bit),
    .found     (w_found),
    .pos       (w_pos),
    .zeros     (w_zeros)
  );

  // scan step values
  logic                 last_row;
  logic [BLK_CNT_W-1:0] acc_sum;

  assign last_row = find_ino ? (scan_row == ROW_W'(INO_ROWS - 1))
                             : (scan_row == ROW_W'(BLK_ROWS - 1));
  assign acc_sum  = acc + BLK_CNT_W'(w_zeros);

  // read-modify-write of one block bit
  logic [WORD_W-1:0] mark_word;
  always_comb begin
    mark_word = blk_rdata;
    mark_word[blk_idx[POS_W-1:0]] = (op == OP_MARK_USED);
  end

  assign map_wr.en   = (state == S_MARK);
  assign map_wr.addr = scan_row;
  assign map_wr.data = mark_word;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inode_map <= '0;
      free_blk  <= BLK_CNT_W'(BLOCK_COUNT);
      free_ino  <= INO_CNT_W'(INODE_COUNT);
      m_tvalid  <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded instead
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op          <= in_op;
            blk_idx     <= in_blk_idx;
            needed      <= in_needed;
            acc         <= '0;
            res_status  <= 1'b0;
            res_blk_num <= '0;
            res_ino     <= '0;
            case (in_op)
              OP_FIND_BLOCK, OP_CHECK: begin
                scan_row <= '0;
                state    <= S_FETCH;
              end
              OP_FIND_INODE: begin
                scan_row <= ROW_W'(INO_FIRST_ROW);
                state    <= S_FETCH;
              end
              OP_MARK_USED, OP_MARK_FREE: begin
                // inode side is done here; block side needs its row
                if (in_ino_vld) begin
                  inode_map[in_ino_idx] <= (in_op == OP_MARK_USED);
                  if (in_op == OP_MARK_USED) begin
                    if (free_ino != '0) free_ino <= free_ino - INO_CNT_W'(1);
                  end else begin
                    if (free_ino != INO_CNT_W'(INODE_COUNT)) begin
                      free_ino <= free_ino + INO_CNT_W'(1);
                    end
                  end
                end
                scan_row <= in_blk_idx[BLK_IDX_W-1:POS_W];
                state    <= in_blk_vld ? S_FETCH : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FETCH: begin
          state <= (op == OP_MARK_USED || op == OP_MARK_FREE) ? S_MARK : S_SCAN;
        end
        S_SCAN: begin
          case (op)
            OP_FIND_BLOCK: begin
              if (w_found) begin
                res_blk_num <= BLK_CNT_W'({scan_row, w_pos}) + BLK_CNT_W'(1);
                state       <= S_DONE;
              end else if (last_row) begin
                res_status <= 1'b1;
                state      <= S_DONE;
              end else begin
                scan_row <= scan_row + ROW_W'(1);
              end
            end
            OP_FIND_INODE: begin
              if (w_found) begin
                res_ino <= INO_IDX_W'({scan_row, w_pos});
                state   <= S_DONE;
              end else if (last_row) begin
                res_status <= 1'b1;
                state      <= S_DONE;
              end else begin
                scan_row <= scan_row + ROW_W'(1);
              end
            end
            OP_CHECK: begin
              acc <= acc_sum;
              if (last_row) begin
                res_status <= (needed > acc_sum);
                state      <= S_DONE;
              end else begin
                scan_row <= scan_row + ROW_W'(1);
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_MARK: begin
          // counter moves whether or not the bit changed
          if (op == OP_MARK_USED) begin
            if (free_blk != '0) free_blk <= free_blk - BLK_CNT_W'(1);
          end else begin
            if (free_blk != BLK_CNT_W'(BLOCK_COUNT)) free_blk <= free_blk + BLK_CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0, free_ino, free_blk, res_ino, res_blk_num, res_status};
    end
  end

  `BIBA_ASSERT_NOW(a_blk_cnt_range, 1'b1, free_blk <= BLK_CNT_W'(BLOCK_COUNT))
  `BIBA_ASSERT_NOW(a_ino_cnt_range, 1'b1, free_ino <= INO_CNT_W'(INODE_COUNT))
  `BIBA_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
  `BIBA_ASSERT_NEXT(a_mark_one_write, state == S_MARK, state == S_DONE && !map_wr.en)
  `BIBA_ASSERT_NOW(a_fail_no_number, m_tvalid && m_tdata[0], m_tdata[13:1] == 13'd0)

endmodule
